@@ rtl/pawk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and codes for the polyline arc-length walker.
// No dependencies; every other file but pawk_ram imports this package.
package pawk_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int FRAC_W       = 16;
	localparam int COORD_W      = 20;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int SQ_W         = 2 * DIFF_W;
	localparam int LEN_W        = SQ_W / 2;
	localparam int STEP_W       = 16;
	localparam int DIST_W       = STEP_W + FRAC_W;
	localparam int REM_W        = LEN_W + FRAC_W + 1;
	localparam int PROD_W       = DIFF_W + FRAC_W + 1;
	localparam int SQRT_STEPS   = SQ_W / 2;
	localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
	localparam int DIV_CNT_W    = $clog2(DIST_W);

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16);

	localparam logic [1:0] FUNC_CLEAR     = 2'd0;
	localparam logic [1:0] FUNC_APPEND    = 2'd1;
	localparam logic [1:0] FUNC_ADVANCE   = 2'd2;
	localparam logic [1:0] FUNC_RESET_POS = 2'd3;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_FEW  = 2'd2;

	localparam logic [1:0] RD_SEL_I    = 2'd0;
	localparam logic [1:0] RD_SEL_NEXT = 2'd1;
	localparam logic [1:0] RD_SEL_ZERO = 2'd2;

	localparam logic DIV_SEL_QUOT = 1'b0;
	localparam logic DIV_SEL_MOD  = 1'b1;

	typedef struct packed {
		logic [1:0]                func;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] current_x;
		logic signed [COORD_W-1:0] current_y;
		logic [IDX_W-1:0]          segment_index;
		logic [FRAC_W-1:0]         segment_fraction;
		logic [1:0]                status;
	} out_item_t;

	typedef struct packed {
		logic       take;
		logic       clear_all;
		logic       append;
		logic       pos_zero;
		logic       status_we;
		logic [1:0] status_val;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_a;
		logic       cap_b;
		logic       cap_v0;
		logic       diff;
		logic       square;
		logic       sqrt_start;
		logic       rem_calc;
		logic       div_start;
		logic       div_sel;
		logic       step_seg;
		logic       wrap;
		logic       pt_b;
		logic       pos_at_i;
		logic       mod_take;
		logic       mark_set;
		logic       frac_take;
		logic       lerp_mul;
		logic       lerp_fin;
		logic       adv_init;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       cnt_ge1;
		logic       cnt_ge2;
		logic       cnt_full;
		logic       step_zero;
		logic       d_lt_rem;
		logic       i_last;
		logic       d_zero;
		logic       wrapped;
		logic       lap_zero;
		logic       sqrt_done;
		logic       div_done;
		logic       out_free;
	} dp_stat_t;

endpackage

@@ rtl/pawk_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module pawk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pawk_sqrt.sv @@
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle.
// Depends on pawk_pkg.
module pawk_sqrt import pawk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  operand,
	output logic             done,
	output logic [LEN_W-1:0] root
);

	localparam int ACC_W = LEN_W + 4;

	logic [SQ_W-1:0]       rad_q;
	logic [ACC_W-1:0]      acc_q;
	logic [LEN_W-1:0]      root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ACC_W-1:0]      acc_sh;
	logic [ACC_W-1:0]      trial;
	logic                  fits;

	assign acc_sh = {acc_q[ACC_W-3:0], rad_q[SQ_W-1:SQ_W-2]};
	assign trial  = {{(ACC_W-LEN_W-2){1'b0}}, root_q, 2'b01};
	assign fits   = acc_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= operand;
			acc_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			acc_q  <= fits ? acc_sh - trial : acc_sh;
			root_q <= {root_q[LEN_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/pawk_div.sv @@
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pawk_pkg.
module pawk_div import pawk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] dividend,
	input  logic [DIST_W-1:0] divisor,
	output logic              done,
	output logic [DIST_W-1:0] quotient,
	output logic [DIST_W-1:0] remainder
);

	logic [DIST_W:0]       rem_q;
	logic [DIST_W-1:0]     quo_q;
	logic [DIST_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIST_W:0]       rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q[DIST_W-1:0], quo_q[DIST_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIST_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIST_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[DIST_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DIST_W-1:0];

endmodule

@@ rtl/pawk_dp.sv @@
`timescale 1ns / 1ps
// Datapath: vertex RAM, position and point registers, walk arithmetic, output register.
// Depends on pawk_pkg, pawk_ram, pawk_sqrt and pawk_div.
module pawk_dp import pawk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  in_item_t          in_item,
	input  logic              cfg_wr_en,
	input  logic [STEP_W-1:0] cfg_wr_data,
	input  logic              out_stall,
	output logic              out_valid,
	output out_item_t         out_item
);

	localparam logic signed [PROD_W-1:0] RND =
		{{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
	localparam logic signed [COORD_W+2:0] SAT_MAX = {4'b0000, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W+2:0] SAT_MIN = {4'b1111, {(COORD_W-1){1'b0}}};

	function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [COORD_W+2:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[COORD_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	logic [CNT_W-1:0]          cnt_q;
	logic [IDX_W-1:0]          idx_q;
	logic [FRAC_W-1:0]         frac_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic [STEP_W-1:0]         step_q;
	logic                      wrapped_q;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	out_item_t                 out_q;

	logic [1:0]                func_q;
	logic signed [COORD_W-1:0] item_x_q, item_y_q;
	logic [IDX_W-1:0]          i_q;
	logic [FRAC_W-1:0]         f_q;
	logic [DIST_W-1:0]         d_q, mark_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [DIFF_W-1:0]  dx_q, dy_q;
	logic [SQ_W-2:0]           dxx_q, dyy_q;
	logic [REM_W-1:0]          rem_q;
	logic signed [PROD_W-1:0]  prx_q, pry_q;

	logic [CNT_W-1:0]          last_w;
	logic [IDX_W-1:0]          raddr;
	logic [2*COORD_W-1:0]      rdata;
	logic signed [COORD_W-1:0] rd_x, rd_y;
	logic signed [SQ_W-1:0]    sqx_w, sqy_w;
	logic [SQ_W-1:0]           sq_sum;
	logic [FRAC_W:0]           one_minus_f;
	logic [DIST_W-1:0]         lap_w;
	logic [DIST_W-1:0]         div_dvs;
	logic                      sqrt_done, div_done;
	logic [LEN_W-1:0]          len;
	logic [DIST_W-1:0]         quo, div_rem;
	logic [FRAC_W-1:0]         f_next;
	logic signed [PROD_W-1:0]  rx_w, ry_w;
	logic signed [PROD_W-FRAC_W-1:0] qx_w, qy_w;
	logic signed [COORD_W+2:0] sx_w, sy_w;

	assign last_w      = cnt_q - 1'b1;
	assign rd_x        = rdata[2*COORD_W-1:COORD_W];
	assign rd_y        = rdata[COORD_W-1:0];
	assign sqx_w       = dx_q * dx_q;
	assign sqy_w       = dy_q * dy_q;
	assign sq_sum      = {1'b0, dxx_q} + {1'b0, dyy_q};
	assign one_minus_f = {1'b1, {FRAC_W{1'b0}}} - {1'b0, f_q};
	assign lap_w       = mark_q - d_q;
	assign div_dvs     = (cmd.div_sel == DIV_SEL_MOD) ? lap_w
		: {{(DIST_W-LEN_W){1'b0}}, len};
	assign f_next      = f_q + quo[FRAC_W-1:0];
	assign rx_w        = prx_q + RND;
	assign ry_w        = pry_q + RND;
	assign qx_w        = rx_w[PROD_W-1:FRAC_W];
	assign qy_w        = ry_w[PROD_W-1:FRAC_W];
	assign sx_w        = {{3{ax_q[COORD_W-1]}}, ax_q} + {qx_w[PROD_W-FRAC_W-1], qx_w};
	assign sy_w        = {{3{ay_q[COORD_W-1]}}, ay_q} + {qy_w[PROD_W-FRAC_W-1], qy_w};

	always_comb begin
		case (cmd.rd_sel)
			RD_SEL_I:    raddr = i_q;
			RD_SEL_NEXT: raddr = i_q + 1'b1;
			default:     raddr = '0;
		endcase
	end

	pawk_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_VERTICES)) u_vram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata ({item_x_q, item_y_q}),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	pawk_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sqrt_start),
		.operand (sq_sum),
		.done    (sqrt_done),
		.root    (len)
	);

	pawk_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (d_q),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			frac_q      <= '0;
			px_q        <= '0;
			py_q        <= '0;
			step_q      <= STEP_RESET;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				step_q <= cfg_wr_data;
			end
			if (cmd.clear_all) begin
				cnt_q  <= '0;
				idx_q  <= '0;
				frac_q <= '0;
				px_q   <= '0;
				py_q   <= '0;
			end
			if (cmd.append) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.pos_zero || cmd.wrap) begin
				idx_q  <= '0;
				frac_q <= '0;
			end
			if (cmd.pos_at_i) begin
				idx_q  <= i_q;
				frac_q <= '0;
			end
			if (cmd.frac_take) begin
				idx_q  <= i_q;
				frac_q <= f_next;
			end
			if (cmd.cap_v0) begin
				px_q <= rd_x;
				py_q <= rd_y;
			end
			if (cmd.pt_b) begin
				px_q <= bx_q;
				py_q <= by_q;
			end
			if (cmd.lerp_fin) begin
				px_q <= sat_coord(sx_w);
				py_q <= sat_coord(sy_w);
			end
			if (cmd.adv_init) begin
				wrapped_q <= 1'b0;
			end
			if (cmd.mark_set) begin
				wrapped_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q   <= in_item.func;
			item_x_q <= in_item.point_x;
			item_y_q <= in_item.point_y;
			status_q <= STATUS_OK;
		end
		if (cmd.status_we) begin
			status_q <= cmd.status_val;
		end
		if (cmd.adv_init) begin
			d_q    <= {step_q, {FRAC_W{1'b0}}};
			mark_q <= '0;
			if ({1'b0, idx_q} >= last_w) begin
				i_q <= '0;
				f_q <= '0;
			end else begin
				i_q <= idx_q;
				f_q <= frac_q;
			end
		end
		if (cmd.cap_a) begin
			ax_q <= rd_x;
			ay_q <= rd_y;
		end
		if (cmd.cap_b) begin
			bx_q <= rd_x;
			by_q <= rd_y;
		end
		if (cmd.diff) begin
			dx_q <= {bx_q[COORD_W-1], bx_q} - {ax_q[COORD_W-1], ax_q};
			dy_q <= {by_q[COORD_W-1], by_q} - {ay_q[COORD_W-1], ay_q};
		end
		if (cmd.square) begin
			dxx_q <= sqx_w[SQ_W-2:0];
			dyy_q <= sqy_w[SQ_W-2:0];
		end
		if (cmd.rem_calc) begin
			rem_q <= {{(REM_W-LEN_W){1'b0}}, len}
				* {{(REM_W-FRAC_W-1){1'b0}}, one_minus_f};
		end
		if (cmd.step_seg) begin
			d_q <= d_q - rem_q[DIST_W-1:0];
			i_q <= i_q + 1'b1;
			f_q <= '0;
		end
		if (cmd.wrap) begin
			i_q <= '0;
		end
		if (cmd.mod_take) begin
			d_q <= div_rem;
		end
		if (cmd.mark_set) begin
			mark_q <= d_q;
		end
		if (cmd.frac_take) begin
			f_q <= f_next;
		end
		if (cmd.lerp_mul) begin
			prx_q <= dx_q * $signed({1'b0, f_q});
			pry_q <= dy_q * $signed({1'b0, f_q});
		end
		if (cmd.out_load) begin
			out_q.current_x        <= px_q;
			out_q.current_y        <= py_q;
			out_q.segment_index    <= idx_q;
			out_q.segment_fraction <= frac_q;
			out_q.status           <= status_q;
		end
	end

	always_comb begin
		stat.func      = func_q;
		stat.cnt_ge1   = cnt_q != '0;
		stat.cnt_ge2   = cnt_q >= CNT_W'(2);
		stat.cnt_full  = cnt_q == CNT_W'(MAX_VERTICES);
		stat.step_zero = step_q == '0;
		stat.d_lt_rem  = {{(REM_W-DIST_W){1'b0}}, d_q} < rem_q;
		stat.i_last    = {1'b0, i_q} == last_w;
		stat.d_zero    = d_q == '0;
		stat.wrapped   = wrapped_q;
		stat.lap_zero  = lap_w == '0;
		stat.sqrt_done = sqrt_done;
		stat.div_done  = div_done;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ rtl/pawk_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences each item through the datapath by command and status.
// Depends on pawk_pkg.
module pawk_ctrl import pawk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_V0_RD, S_V0_CAP, S_RD_A, S_RD_B, S_CAP_B, S_DIFF,
		S_SQUARE, S_SQRT_GO, S_SQRT_WAIT, S_REM, S_CMP, S_DIV_WAIT, S_LERP_MUL,
		S_LERP_FIN, S_SEG_END, S_MOD_WAIT, S_MOD_END, S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					case (stat.func)
						FUNC_ADVANCE: state_q <= (stat.cnt_ge2 && !stat.step_zero)
							? S_RD_A : S_EMIT;
						FUNC_RESET_POS: state_q <= stat.cnt_ge1 ? S_V0_RD : S_EMIT;
						default: state_q <= S_EMIT;
					endcase
				end
				S_V0_RD:     state_q <= S_V0_CAP;
				S_V0_CAP:    state_q <= S_EMIT;
				S_RD_A:      state_q <= S_RD_B;
				S_RD_B:      state_q <= S_CAP_B;
				S_CAP_B:     state_q <= S_DIFF;
				S_DIFF:      state_q <= S_SQUARE;
				S_SQUARE:    state_q <= S_SQRT_GO;
				S_SQRT_GO:   state_q <= S_SQRT_WAIT;
				S_SQRT_WAIT: if (stat.sqrt_done) state_q <= S_REM;
				S_REM:       state_q <= S_CMP;
				S_CMP:       state_q <= stat.d_lt_rem ? S_DIV_WAIT : S_SEG_END;
				S_DIV_WAIT:  if (stat.div_done) state_q <= S_LERP_MUL;
				S_LERP_MUL:  state_q <= S_LERP_FIN;
				S_LERP_FIN:  state_q <= S_EMIT;
				S_SEG_END: begin
					if (stat.i_last) begin
						if (stat.d_zero) begin
							state_q <= S_EMIT;
						end else if (stat.wrapped) begin
							state_q <= stat.lap_zero ? S_V0_RD : S_MOD_WAIT;
						end else begin
							state_q <= S_RD_A;
						end
					end else begin
						state_q <= stat.d_zero ? S_EMIT : S_RD_A;
					end
				end
				S_MOD_WAIT: if (stat.div_done) state_q <= S_MOD_END;
				S_MOD_END:  state_q <= stat.d_zero ? S_EMIT : S_RD_A;
				S_EMIT:     if (stat.out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.take = in_valid;
			S_DECODE: begin
				case (stat.func)
					FUNC_CLEAR: cmd.clear_all = 1'b1;
					FUNC_APPEND: begin
						if (stat.cnt_full) begin
							cmd.status_we  = 1'b1;
							cmd.status_val = STATUS_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					FUNC_ADVANCE: begin
						if (!stat.cnt_ge2) begin
							cmd.status_we  = 1'b1;
							cmd.status_val = STATUS_FEW;
						end else if (!stat.step_zero) begin
							cmd.adv_init = 1'b1;
						end
					end
					default: begin
						cmd.pos_zero = 1'b1;
						if (!stat.cnt_ge2) begin
							cmd.status_we  = 1'b1;
							cmd.status_val = STATUS_FEW;
						end
					end
				endcase
			end
			S_V0_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SEL_ZERO;
			end
			S_V0_CAP: cmd.cap_v0 = 1'b1;
			S_RD_A: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SEL_I;
			end
			S_RD_B: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SEL_NEXT;
				cmd.cap_a  = 1'b1;
			end
			S_CAP_B:   cmd.cap_b = 1'b1;
			S_DIFF:    cmd.diff = 1'b1;
			S_SQUARE:  cmd.square = 1'b1;
			S_SQRT_GO: cmd.sqrt_start = 1'b1;
			S_REM:     cmd.rem_calc = 1'b1;
			S_CMP: begin
				if (stat.d_lt_rem) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SEL_QUOT;
				end else begin
					cmd.step_seg = 1'b1;
				end
			end
			S_DIV_WAIT: cmd.frac_take = stat.div_done;
			S_LERP_MUL: cmd.lerp_mul = 1'b1;
			S_LERP_FIN: cmd.lerp_fin = 1'b1;
			S_SEG_END: begin
				if (stat.i_last) begin
					cmd.wrap = 1'b1;
					if (stat.d_zero) begin
						cmd.pt_b = 1'b1;
					end else if (stat.wrapped) begin
						if (!stat.lap_zero) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_SEL_MOD;
						end
					end else begin
						cmd.mark_set = 1'b1;
					end
				end else if (stat.d_zero) begin
					cmd.pos_at_i = 1'b1;
					cmd.pt_b     = 1'b1;
				end
			end
			S_MOD_WAIT: cmd.mod_take = stat.div_done;
			S_MOD_END: begin
				if (stat.d_zero) begin
					cmd.pt_b = 1'b1;
				end else begin
					cmd.mark_set = 1'b1;
				end
			end
			S_EMIT:  cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

	assign in_stall = state_q != S_IDLE;

endmodule

@@ rtl/polyline_arc_length_walker.sv @@
`timescale 1ns / 1ps
// Polyline arc-length walker: keeps a vertex table and a position, and walks it.
// Top level; depends on pawk_pkg, pawk_ctrl and pawk_dp.
//
// Input channel in_valid/in_stall/in_item carries commands: clear table, append
// vertex, advance by step_distance, reset position. Output channel
// out_valid/out_stall/out_item returns one result per command: the current
// point, segment index, fraction and status. step_distance is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while the block is idle,
// as the block itself does not enforce it. One item is worked on at a time.
// An advance runs the square root for each segment it visits, and the
// divider for a lap reduction and for an end inside a segment.
// A finished result sits in the output register; while the receiver stalls,
// the next item is still taken and worked up to its own result, then held.
// Reset clears the table, position and point, and sets step_distance to 16.
module polyline_arc_length_walker import pawk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              cfg_wr_en,
	input  logic [STEP_W-1:0] cfg_wr_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pawk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pawk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_item    (out_item)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transfer taken while an item is in progress");

	a_few_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status == STATUS_FEW)
		|-> (out_item.segment_index == '0 && out_item.segment_fraction == '0))
		else $error("position moved with fewer than two vertices");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.status == STATUS_OK || out_item.status == STATUS_FULL
			|| out_item.status == STATUS_FEW))
		else $error("undefined status on output");

endmodule
